// ===== sv/fixed_to_decimal_digits_assert.svh =====
// Assertion macros for the decimal digit converter.
// The clock and reset of the enclosing scope are used.
`ifndef FIXED_TO_DECIMAL_DIGITS_ASSERT_SVH
`define FIXED_TO_DECIMAL_DIGITS_ASSERT_SVH

// Same-cycle implication, off during reset.
`define FTDD_ASSERT_IMPL(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("ftdd: assertion failed");

// Next-cycle implication, off during reset.
`define FTDD_ASSERT_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("ftdd: assertion failed");

// Next-cycle implication that also holds across reset.
`define FTDD_ASSERT_NEXT_ALWAYS(label, cond, conseq) \
   label: assert property (@(posedge clock) (cond) |=> (conseq)) \
      else $error("ftdd: assertion failed");

`endif

// ===== sv/ftdd_pkg.sv =====
package ftdd_pkg;

   localparam int VALUE_WIDTH    = 48;
   localparam int PLACES_WIDTH   = 3;
   localparam int DIGIT_WIDTH    = 4;
   localparam int NUM_DIGITS     = 5;
   localparam int BCD_WIDTH      = DIGIT_WIDTH * NUM_DIGITS;
   localparam int WHOLE_WIDTH    = 17;
   localparam int SCALE_WIDTH    = 14;
   localparam int SCALED_WIDTH   = VALUE_WIDTH + SCALE_WIDTH;
   localparam int LIMIT_WIDTH    = 3;
   localparam int REQ_DATA_WIDTH = 56;
   localparam int RSP_DATA_WIDTH = 24;
   localparam int RSP_USER_WIDTH = 2;

   localparam int FRACTION_BITS_DEFAULT = 16;

   // binary-to-BCD shift steps per pipeline stage
   localparam int STEPS_A = 6;
   localparam int STEPS_B = 6;
   localparam int STEPS_C = WHOLE_WIDTH - STEPS_A - STEPS_B;

   localparam logic [WHOLE_WIDTH-1:0] MAX_SHOWN  = WHOLE_WIDTH'(99999);
   localparam logic [DIGIT_WIDTH-1:0] BLANK_CODE = DIGIT_WIDTH'(10);
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_MIN = DIGIT_WIDTH'(5);
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD = DIGIT_WIDTH'(3);

   // travels alongside the digits
   typedef struct packed {
      logic                   neg;
      logic                   sat;
      logic [LIMIT_WIDTH-1:0] limit;
   } side_type;

   typedef struct packed {
      logic [BCD_WIDTH-1:0]   bcd;
      logic [WHOLE_WIDTH-1:0] bin;
   } dabble_type;

   // one double-dabble step: correct each digit, then shift one binary bit in
   function automatic dabble_type dabble_step(input dabble_type x);
      dabble_type             y;
      logic [DIGIT_WIDTH-1:0] d;
      y = x;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         d = x.bcd[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         if (d >= DABBLE_MIN) begin
            d = d + DABBLE_ADD;
         end
         y.bcd[i*DIGIT_WIDTH +: DIGIT_WIDTH] = d;
      end
      y = {y.bcd[BCD_WIDTH-2:0], y.bin, 1'b0};
      return y;
   endfunction

endpackage

// ===== sv/ftdd_dabble.sv =====
module ftdd_dabble #(
   parameter int STEPS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                in_valid,
   input  ftdd_pkg::dabble_type in_word,
   input  ftdd_pkg::side_type   in_side,
   output logic                out_valid,
   output ftdd_pkg::dabble_type out_word,
   output ftdd_pkg::side_type   out_side
);
   import ftdd_pkg::*;

   logic       valid_ff;
   dabble_type word_ff;
   dabble_type word_in;
   side_type   side_ff;

   always_comb begin
      word_in = in_word;
      for (int s = 0; s < STEPS; s++) begin
         word_in = dabble_step(word_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;
   assign out_side  = side_ff;

endmodule

// ===== sv/fixed_to_decimal_digits.sv =====
// Fixed-point reading to five display digits. A signed reading with
// FRACTION_BITS fraction bits and a count of decimal places (1 to 4; any
// other count means none) give a sign flag, five digit codes and a
// saturation flag. The magnitude is scaled by 10^places, rounded half up and
// capped at 99999; leading zeros among the first (4 - places) digits, or the
// first four with no valid place count, show as code 10 (blank). A negative
// reading that rounds to zero still reports is_negative. The block takes one
// item per clock while the output is not stalled; each item passes through
// seven register stages: magnitude, 48x14 multiply, round and cap, three
// double-dabble stages, and the output register with the blanking logic.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up under a stalled output.
module fixed_to_decimal_digits #(
   parameter int FRACTION_BITS = ftdd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata, from bit 0: value_fixed[47:0], decimal_places[2:0], zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ftdd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // rsp_tdata, from bit 0: digit_ten_thousands, digit_thousands,
   //   digit_hundreds, digit_tens, digit_units (4 bits each), zero fill
   // rsp_tuser, from bit 0: is_negative, saturated
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ftdd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [ftdd_pkg::RSP_USER_WIDTH-1:0] rsp_tuser
);
   import ftdd_pkg::*;

   // rounding bit sits just below the binary point
   localparam int RND_IDX = (FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0;

   // stage enables, from the output back
   logic en_out, en_c, en_b, en_a, en3, en2, en1;

   // stage 1: sign and magnitude, scale and blank limit
   logic                      v1_ff;
   logic                      neg1_ff, neg1_in;
   logic [VALUE_WIDTH-1:0]    mag1_ff, mag1_in;
   logic [SCALE_WIDTH-1:0]    scale1_ff, scale1_in;
   logic [LIMIT_WIDTH-1:0]    limit1_ff, limit1_in;
   logic [VALUE_WIDTH-1:0]    raw;
   logic [PLACES_WIDTH-1:0]   places;

   // stage 2: scaled magnitude
   logic                      v2_ff;
   logic [SCALED_WIDTH-1:0]   scaled2_ff, scaled2_in;
   logic                      neg2_ff;
   logic [LIMIT_WIDTH-1:0]    limit2_ff;

   // stage 3: rounded, capped integer
   logic                      v3_ff;
   logic [WHOLE_WIDTH-1:0]    whole3_ff, whole3_in;
   side_type                  side3_ff, side3_in;
   logic [SCALED_WIDTH-1:0]   whole_wide;
   logic                      rnd;
   logic                      over;

   // double-dabble stages
   logic       va, vb, vc;
   dabble_type word3, word_a, word_b, word_c;
   side_type   side_a, side_b, side_c;

   // output register
   logic                      out_v_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_WIDTH-1:0] rsp_user_ff, rsp_user_in;
   logic [DIGIT_WIDTH-1:0]    dig;
   logic                      run;

   assign en_out     = !out_v_ff || rsp_tready;
   assign en_c       = !vc       || en_out;
   assign en_b       = !vb       || en_c;
   assign en_a       = !va       || en_b;
   assign en3        = !v3_ff    || en_a;
   assign en2        = !v2_ff    || en3;
   assign en1        = !v1_ff    || en2;
   assign req_tready = en1;

   // ---- stage 1 ----
   assign raw    = req_tdata[VALUE_WIDTH-1:0];
   assign places = req_tdata[VALUE_WIDTH +: PLACES_WIDTH];

   always_comb begin
      neg1_in = raw[VALUE_WIDTH-1];
      // the most negative reading negates to 2^47, which fits unsigned
      mag1_in = neg1_in ? (~raw + VALUE_WIDTH'(1)) : raw;
      unique case (places)
         3'd1: begin
            scale1_in = SCALE_WIDTH'(10);
            limit1_in = LIMIT_WIDTH'(3);
         end
         3'd2: begin
            scale1_in = SCALE_WIDTH'(100);
            limit1_in = LIMIT_WIDTH'(2);
         end
         3'd3: begin
            scale1_in = SCALE_WIDTH'(1000);
            limit1_in = LIMIT_WIDTH'(1);
         end
         3'd4: begin
            scale1_in = SCALE_WIDTH'(10000);
            limit1_in = LIMIT_WIDTH'(0);
         end
         default: begin
            // no valid place count: whole units, four digits may blank
            scale1_in = SCALE_WIDTH'(1);
            limit1_in = LIMIT_WIDTH'(4);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         neg1_ff   <= neg1_in;
         mag1_ff   <= mag1_in;
         scale1_ff <= scale1_in;
         limit1_ff <= limit1_in;
      end
   end

   // ---- stage 2: exact product ----
   assign scaled2_in = SCALED_WIDTH'(mag1_ff) * SCALED_WIDTH'(scale1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         scaled2_ff <= scaled2_in;
         neg2_ff    <= neg1_ff;
         limit2_ff  <= limit1_ff;
      end
   end

   // ---- stage 3: round half up and cap ----
   always_comb begin
      whole_wide = scaled2_ff >> FRACTION_BITS;
      rnd        = (FRACTION_BITS > 0) ? scaled2_ff[RND_IDX] : 1'b0;
      // cap when the integer part is already too big, or rounding pushes it over
      over = (|whole_wide[SCALED_WIDTH-1:WHOLE_WIDTH])
             || (whole_wide[WHOLE_WIDTH-1:0] > MAX_SHOWN)
             || ((whole_wide[WHOLE_WIDTH-1:0] == MAX_SHOWN) && rnd);
      whole3_in = over ? MAX_SHOWN
                       : whole_wide[WHOLE_WIDTH-1:0] + WHOLE_WIDTH'(rnd);
      side3_in.neg   = neg2_ff;
      side3_in.sat   = over;
      side3_in.limit = limit2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         whole3_ff <= whole3_in;
         side3_ff  <= side3_in;
      end
   end

   // ---- stages 4 to 6: binary to BCD, six, six and five shift steps ----
   assign word3.bcd = '0;
   assign word3.bin = whole3_ff;

   ftdd_dabble #(.STEPS(STEPS_A)) u_dabble_a (
      .clock     (clock),
      .reset     (reset),
      .load      (en_a),
      .in_valid  (v3_ff),
      .in_word   (word3),
      .in_side   (side3_ff),
      .out_valid (va),
      .out_word  (word_a),
      .out_side  (side_a)
   );

   ftdd_dabble #(.STEPS(STEPS_B)) u_dabble_b (
      .clock     (clock),
      .reset     (reset),
      .load      (en_b),
      .in_valid  (va),
      .in_word   (word_a),
      .in_side   (side_a),
      .out_valid (vb),
      .out_word  (word_b),
      .out_side  (side_b)
   );

   ftdd_dabble #(.STEPS(STEPS_C)) u_dabble_c (
      .clock     (clock),
      .reset     (reset),
      .load      (en_c),
      .in_valid  (vb),
      .in_word   (word_b),
      .in_side   (side_b),
      .out_valid (vc),
      .out_word  (word_c),
      .out_side  (side_c)
   );

   // ---- stage 7: leading-zero blanking and output register ----
   // BCD holds the ten-thousands digit at the top; tdata wants it at the bottom
   always_comb begin
      run         = 1'b1;
      rsp_data_in = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dig = word_c.bcd[(NUM_DIGITS-1-i)*DIGIT_WIDTH +: DIGIT_WIDTH];
         run = run && (LIMIT_WIDTH'(i) < side_c.limit) && (dig == '0);
         rsp_data_in[i*DIGIT_WIDTH +: DIGIT_WIDTH] = run ? BLANK_CODE : dig;
      end
      rsp_user_in = {side_c.sat, side_c.neg};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en_out) begin
         out_v_ff <= vc;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sv/ftdd_checker.sv =====
`include "fixed_to_decimal_digits_assert.svh"

module ftdd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [ftdd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ftdd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [ftdd_pkg::RSP_USER_WIDTH-1:0] rsp_tuser
);
   import ftdd_pkg::*;

   logic [DIGIT_WIDTH-1:0] d_tt, d_th, d_hu, d_te, d_un;
   logic                   sat;
   logic                   in_seen;
   logic                   all_nines;

   assign d_tt    = rsp_tdata[0*DIGIT_WIDTH +: DIGIT_WIDTH];
   assign d_th    = rsp_tdata[1*DIGIT_WIDTH +: DIGIT_WIDTH];
   assign d_hu    = rsp_tdata[2*DIGIT_WIDTH +: DIGIT_WIDTH];
   assign d_te    = rsp_tdata[3*DIGIT_WIDTH +: DIGIT_WIDTH];
   assign d_un    = rsp_tdata[4*DIGIT_WIDTH +: DIGIT_WIDTH];
   assign sat     = rsp_tuser[1];
   assign in_seen = req_tvalid && req_tready && (|req_tdata);

   assign all_nines = (d_tt == 4'd9) && (d_th == 4'd9) && (d_hu == 4'd9)
                      && (d_te == 4'd9) && (d_un == 4'd9);

   // pipeline is flushed by reset
   `FTDD_ASSERT_NEXT_ALWAYS(a_reset_flush, reset, !rsp_tvalid)

   // a capped result always reads 9 9 9 9 9
   `FTDD_ASSERT_IMPL(a_sat_nines, rsp_tvalid && sat, all_nines)

   // units digit is never blanked and always decimal
   `FTDD_ASSERT_IMPL(a_units_decimal, rsp_tvalid, d_un <= 4'd9)

   // blanking runs from the left without gaps
   `FTDD_ASSERT_IMPL(a_blank_leading, rsp_tvalid && (d_th == BLANK_CODE), (d_tt == BLANK_CODE) && !sat)

   // a stalled item holds
   `FTDD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready && !in_seen, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind fixed_to_decimal_digits ftdd_checker u_ftdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/fixed_to_decimal_digits_tb.sv =====
module fixed_to_decimal_digits_tb;
   import ftdd_pkg::*;

   // The block under test runs with its default fraction width.
   localparam int FRAC_BITS = FRACTION_BITS_DEFAULT;

   // Expected readout of one item: the sign, five digit codes (index 0 is the
   // ten-thousands digit) and the cap flag.
   typedef struct packed {
      logic                             neg;
      logic [NUM_DIGITS-1:0][DIGIT_WIDTH-1:0] digit;
      logic                             sat;
   } readout_type;

   // Holds the readouts still owed by the block, in order of acceptance.
   class digit_scoreboard;
      readout_type awaiting[$];
      int          failures    = 0;
      int          readings    = 0;
      int          results     = 0;
      int          saturations = 0;
      int          negatives   = 0;

      // Scale the magnitude by 10^places, round half up, cap, split into
      // decimal digits and blank the leading zeros.
      function readout_type predict(input logic [VALUE_WIDTH-1:0]  value,
                                    input logic [PLACES_WIDTH-1:0] places);
         readout_type            r;
         logic [VALUE_WIDTH-1:0] mag;
         logic [63:0]            scale;
         logic [63:0]            scaled;
         logic [63:0]            whole;
         int                     limit;
         r     = '0;
         r.neg = value[VALUE_WIDTH-1];
         // most negative value wraps onto 2^47, which is already its magnitude
         mag   = r.neg ? (~value + 1'b1) : value;
         case (places)
            3'd1:    scale = 64'd10;
            3'd2:    scale = 64'd100;
            3'd3:    scale = 64'd1000;
            3'd4:    scale = 64'd10000;
            default: scale = 64'd1;
         endcase
         scaled = 64'(mag) * scale;
         whole  = scaled >> FRAC_BITS;
         if (scaled[FRAC_BITS-1]) begin
            whole = whole + 64'd1;
         end
         if (whole > 64'(MAX_SHOWN)) begin
            whole = 64'(MAX_SHOWN);
            r.sat = 1'b1;
         end
         r.digit[0] = DIGIT_WIDTH'(whole / 10000);
         r.digit[1] = DIGIT_WIDTH'(whole / 1000 % 10);
         r.digit[2] = DIGIT_WIDTH'(whole / 100 % 10);
         r.digit[3] = DIGIT_WIDTH'(whole / 10 % 10);
         r.digit[4] = DIGIT_WIDTH'(whole % 10);
         limit = (places >= 3'd1 && places <= 3'd4) ? 4 - int'(places) : 4;
         for (int i = 0; i < limit; i++) begin
            if (r.digit[i] != '0) begin
               break;
            end
            r.digit[i] = BLANK_CODE;
         end
         return r;
      endfunction

      function void note_reading(input logic [VALUE_WIDTH-1:0]  value,
                                 input logic [PLACES_WIDTH-1:0] places);
         awaiting.push_back(predict(value, places));
         readings++;
      endfunction

      function void compare(input string field, input int unsigned want,
                            input int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_result(input logic [RSP_DATA_WIDTH-1:0] data,
                                 input logic [RSP_USER_WIDTH-1:0] user);
         readout_type want;
         if (awaiting.size() == 0) begin
            $display("%0t: unexpected item, tdata %h tuser %b", $time, data, user);
            failures++;
            return;
         end
         want = awaiting.pop_front();
         compare("is_negative", want.neg, user[0]);
         compare("saturated", want.sat, user[1]);
         for (int i = 0; i < NUM_DIGITS; i++) begin
            compare($sformatf("digit %0d", i), want.digit[i],
                    data[i*DIGIT_WIDTH +: DIGIT_WIDTH]);
         end
         results++;
         saturations += int'(user[1]);
         negatives   += int'(user[0]);
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   // req_tdata, from bit 0: value_fixed[47:0], decimal_places[2:0], zero fill
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   // rsp_tdata, from bit 0: the five digit codes, ten-thousands first
   // rsp_tuser, from bit 0: is_negative, saturated
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;

   digit_scoreboard board = new();

   fixed_to_decimal_digits u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offer one reading after an idle gap and hold it until it is taken.
   // Called at a rising edge; tvalid only drops when there is a real gap, so
   // back-to-back items keep it high without a second assignment in the step.
   task automatic send_reading(input logic [VALUE_WIDTH-1:0]  value,
                               input logic [PLACES_WIDTH-1:0] places,
                               input int                      gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'({places, value});
      do @(posedge clock); while (!req_tready);
      board.note_reading(value, places);
   endtask

   // Random reading, mostly within the displayable range for the given place
   // count so that the digits and blanking get a proper workout; the rest sit
   // on rounding edges, at the cap, or anywhere in the 48-bit range.
   function automatic logic [VALUE_WIDTH-1:0] draw_reading(
         input logic [PLACES_WIDTH-1:0] places);
      logic [63:0]            scale;
      logic [63:0]            span;
      logic [63:0]            mag;
      logic [63:0]            w;
      logic [VALUE_WIDTH-1:0] value;
      scale = (places >= 3'd1 && places <= 3'd4) ? 64'(10 ** int'(places)) : 64'd1;
      span  = (64'd100000 << FRAC_BITS) / scale;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: mag = {$urandom, $urandom} % span;
         5: return VALUE_WIDTH'({$urandom, $urandom});
         6: begin
            // straddle the half-way point of some display value
            w   = 64'($urandom_range(1, 99999));
            mag = (((w << FRAC_BITS) + (64'd1 << (FRAC_BITS - 1))) / scale)
                  + 64'($urandom_range(0, 2)) - 64'd1;
         end
         7: begin
            // either side of the cap, rounding included
            mag = (((64'd99999 << FRAC_BITS) + (64'd1 << (FRAC_BITS - 1))) / scale)
                  + 64'($urandom_range(0, 4)) - 64'd2;
         end
         8: mag = 64'($urandom_range(0, 200000));
         default: begin
            case ($urandom_range(0, 3))
               0:       return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               1:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
      value = mag[VALUE_WIDTH-1:0];
      if ($urandom_range(0, 1) == 1) begin
         value = ~value + 1'b1;
      end
      return value;
   endfunction

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Stimulus: a directed opening, then random readings with alternating
   // stretches of idling and back-to-back traffic.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero under every place count: blanking width follows the count
      for (int p = 0; p < 8; p++) begin
         send_reading('0, PLACES_WIDTH'(p), draw_gap(p < 4));
      end
      // full-scale extremes, both saturate; most negative keeps its sign
      send_reading({1'b0, {(VALUE_WIDTH-1){1'b1}}}, 3'd0, draw_gap(1'b0));
      send_reading({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 3'd2, draw_gap(1'b0));
      // smallest negative rounds to zero: sign set, four places, nothing blank
      send_reading('1, 3'd4, draw_gap(1'b0));
      // exactly one half rounds up at either sign, just under it rounds down
      send_reading(VALUE_WIDTH'(48'h8000), 3'd0, draw_gap(1'b1));
      send_reading(VALUE_WIDTH'(48'h7FFF), 3'd0, draw_gap(1'b1));
      send_reading(~VALUE_WIDTH'(48'h8000) + 1'b1, 3'd0, draw_gap(1'b1));
      // just below and just at the rounding step to the cap
      send_reading(VALUE_WIDTH'((64'd99999 << FRAC_BITS) | 64'h7FFF), 3'd0,
                   draw_gap(1'b0));
      send_reading(VALUE_WIDTH'((64'd99999 << FRAC_BITS) | 64'h8000), 3'd0,
                   draw_gap(1'b0));
      // four places: 1.2345 shows in full
      send_reading(VALUE_WIDTH'(48'd80904), 3'd4, draw_gap(1'b0));
      send_reading(VALUE_WIDTH'(64'd42 << FRAC_BITS), 3'd1, draw_gap(1'b0));
      send_reading(~VALUE_WIDTH'(64'd7 << FRAC_BITS) + 1'b1, 3'd3, draw_gap(1'b1));
      send_reading(VALUE_WIDTH'(64'd123 << FRAC_BITS), 3'd6, draw_gap(1'b0));
      // ten with four places overflows the display
      send_reading(VALUE_WIDTH'(64'd10 << FRAC_BITS), 3'd4, draw_gap(1'b0));
      send_reading(VALUE_WIDTH'((64'd5 << FRAC_BITS) | 64'h1999), 3'd1,
                   draw_gap(1'b1));
      // alternating bit patterns
      send_reading(VALUE_WIDTH'(48'h5555_5555_5555), 3'd5, draw_gap(1'b0));
      send_reading(VALUE_WIDTH'(48'hAAAA_AAAA_AAAA), 3'd2, draw_gap(1'b0));

      for (int i = 0; i < 700; i++) begin
         logic [PLACES_WIDTH-1:0] places;
         places = PLACES_WIDTH'($urandom_range(0, 7));
         send_reading(draw_reading(places), places, draw_gap((i / 60) % 3 == 2));
      end
      req_tvalid <= 1'b0;

      // drain, then allow the pipeline depth for anything stray
      while (board.awaiting.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d readings, checked %0d results (%0d saturated, %0d negative)",
               board.readings, board.results, board.saturations, board.negatives);
      if (board.failures == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", board.failures);
         $display("FAIL");
      end
      $finish;
   end

   // Result side: random back-pressure, occasional stretches always ready,
   // and twice a long hold so that the pipeline fills and stalls the input.
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (board.results == 40 || board.results == 350) begin
            stall = 90;
         end else begin
            stall = draw_gap((board.results / 64) % 3 == 1);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #3000000;
      $display("Timed out with %0d results outstanding", board.awaiting.size());
      $display("FAIL");
      $finish;
   end

endmodule

// ===== fixed_to_decimal_digits.f =====
+incdir+sv
sv/ftdd_pkg.sv
sv/ftdd_dabble.sv
sv/fixed_to_decimal_digits.sv
sv/ftdd_checker.sv
sim/fixed_to_decimal_digits_tb.sv
